FILE: design/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

   // Default structure
   localparam int SENSORS_DEF   = 5;
   localparam int GAIN_FRAC_DEF = 12;

   // Field widths
   localparam int POS_W      = 12;
   localparam int ERR_W      = 12;
   localparam int DIFF_W     = 13;
   localparam int INTEG_W    = 9;
   localparam int CORR_W     = 9;
   localparam int SPEED_W    = 8;
   localparam int GAIN_W     = 16;
   localparam int TRIM_W     = 9;
   localparam int SUM_W      = 32;
   localparam int SPIN_X_W   = 10;
   localparam int SPIN_Y_W   = 13;
   localparam int RECIP_W    = 13;
   localparam int SPIN_Q_W   = SPIN_Y_W + RECIP_W;
   localparam int RECIP_SH   = 16;
   localparam int MIX_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Tracking constants
   localparam logic [POS_W-1:0]          MAX_POS     = 12'd4000;
   localparam logic [POS_W-1:0]          CENTER_POS  = 12'd2000;
   localparam logic signed [ERR_W-1:0]   LOST_ERROR  = 12'sd20;
   localparam logic signed [DIFF_W-1:0]  INTEG_MAX   = 13'sd200;
   localparam logic signed [DIFF_W-1:0]  INTEG_MIN   = -13'sd200;
   localparam logic [SPEED_W-1:0]        SPEED_MAX   = 8'd255;
   // spin speed = x * 9 / 10, the divide done as a multiply by 2^16/10
   localparam logic [RECIP_W-1:0]        RECIP_TEN   = 13'd6554;

   // Steering modes
   localparam logic [1:0] MODE_FOLLOW   = 2'd0;
   localparam logic [1:0] MODE_SPIN_CW  = 2'd1;
   localparam logic [1:0] MODE_SPIN_CCW = 2'd2;

   // Edge that last saw the line
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CORR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_TRIM  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_TRIM = 3'd6;

   // Register reset values
   localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 16'd205;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 16'd1638;
   localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd70;
   localparam logic [SPEED_W-1:0] MAX_CORR_RST   = 8'd250;

endpackage

FILE: design/line_follow_pid_steering.sv
`timescale 1ns / 1ps

// Each request passes through four register stages (input, error/state, gain
// multipliers, sum/clamp/mix) before its result is valid.
// Throughput: one request per cycle while rsp_ready accepts results.
// Each stage stalls only when the stage after it is full and blocked.
// Reset (synchronous, active high) empties the pipeline, returns to follow
// mode with cleared PID state and loads the default register values.
module line_follow_pid_steering #(
   parameter int SENSORS            = lfps_pkg::SENSORS_DEF,
   parameter int GAIN_FRACTION_BITS = lfps_pkg::GAIN_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lfps_pkg::POS_W-1:0]         req_position,
   input  logic [SENSORS-1:0]                 req_line_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_update,
   output logic [lfps_pkg::SPEED_W-1:0]       rsp_left_speed,
   output logic [lfps_pkg::SPEED_W-1:0]       rsp_right_speed,
   output logic                               rsp_left_forward,
   output logic                               rsp_right_forward,
   output logic signed [lfps_pkg::ERR_W-1:0]  rsp_line_error,
   output logic signed [lfps_pkg::CORR_W-1:0] rsp_correction,
   output logic [1:0]                         rsp_steer_mode,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ERR_W   = lfps_pkg::ERR_W;
   localparam int DIFF_W  = lfps_pkg::DIFF_W;
   localparam int INTEG_W = lfps_pkg::INTEG_W;
   localparam int GAIN_W  = lfps_pkg::GAIN_W;
   localparam int SUM_W   = lfps_pkg::SUM_W;
   localparam int MAG_W   = SUM_W - GAIN_FRACTION_BITS;
   localparam int PP_W    = GAIN_W + 1 + ERR_W;
   localparam int PI_W    = GAIN_W + 1 + INTEG_W;
   localparam int PD_W    = GAIN_W + 1 + DIFF_W;

   // ---------------------------------------------------------------- registers
   logic [GAIN_W-1:0]                  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [lfps_pkg::SPEED_W-1:0]       base_speed_ff, max_corr_ff;
   logic signed [lfps_pkg::TRIM_W-1:0] left_trim_ff, right_trim_ff;

   logic [1:0]                 mode_ff, last_side_ff;
   logic signed [INTEG_W-1:0]  integ_ff;
   logic signed [ERR_W-1:0]    prev_err_ff;

   // pipeline valids and stall chain
   logic v_in_ff, v_b_ff, v_c_ff, v_o_ff;
   logic take_o, take_c, take_b, take_in, adv_in;

   // input stage
   logic [lfps_pkg::POS_W-1:0] pos_ff;
   logic [SENSORS-1:0]         mask_ff;

   // ------------------------------------------------------------ stall chain
   assign take_o    = !v_o_ff || rsp_ready;
   assign take_c    = !v_c_ff || take_o;
   assign take_b    = !v_b_ff || take_c;
   assign take_in   = !v_in_ff || take_b;
   assign adv_in    = v_in_ff && take_b;
   assign req_ready = take_in;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------ config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= lfps_pkg::GAIN_P_RST;
         gain_i_ff     <= lfps_pkg::GAIN_I_RST;
         gain_d_ff     <= lfps_pkg::GAIN_D_RST;
         base_speed_ff <= lfps_pkg::BASE_SPEED_RST;
         max_corr_ff   <= lfps_pkg::MAX_CORR_RST;
         left_trim_ff  <= '0;
         right_trim_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            lfps_pkg::CSR_GAIN_P:     gain_p_ff     <= csr_data;
            lfps_pkg::CSR_GAIN_I:     gain_i_ff     <= csr_data;
            lfps_pkg::CSR_GAIN_D:     gain_d_ff     <= csr_data;
            lfps_pkg::CSR_BASE_SPEED: base_speed_ff <= csr_data[lfps_pkg::SPEED_W-1:0];
            lfps_pkg::CSR_MAX_CORR:   max_corr_ff   <= csr_data[lfps_pkg::SPEED_W-1:0];
            lfps_pkg::CSR_LEFT_TRIM:  left_trim_ff  <= $signed(csr_data[lfps_pkg::TRIM_W-1:0]);
            lfps_pkg::CSR_RIGHT_TRIM: right_trim_ff <= $signed(csr_data[lfps_pkg::TRIM_W-1:0]);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff <= 1'b0;
      end else if (take_in) begin
         v_in_ff <= req_valid;
      end
      if (take_in) begin
         pos_ff  <= req_position;
         mask_ff <= req_line_mask;
      end
   end

   // ------------------------------------------- error and state stage (logic)
   logic [lfps_pkg::POS_W-1:0]   pos_clip;
   logic signed [DIFF_W-1:0]     err_wide, integ_sum, diff_in;
   logic                         mask_empty, left_bit, right_bit, in_spin, hold_in;
   logic                         spin_enter;
   logic [1:0]                   side_base, side_in, mode_new, mode_b_in;
   logic signed [ERR_W-1:0]      err_new, err_b_in;
   logic signed [INTEG_W-1:0]    integ_in;
   logic signed [lfps_pkg::SPIN_X_W-1:0] spin_xl, spin_xr;
   logic [lfps_pkg::SPIN_Y_W-1:0]        spin_yl_in, spin_yr_in;

   always_comb begin
      // clip position and form the raw error
      pos_clip   = (pos_ff > lfps_pkg::MAX_POS) ? lfps_pkg::MAX_POS : pos_ff;
      err_wide   = $signed({1'b0, pos_clip}) - $signed({1'b0, lfps_pkg::CENTER_POS});
      mask_empty = (mask_ff == '0);
      left_bit   = mask_ff[0];
      right_bit  = mask_ff[SENSORS-1];
      in_spin    = (mode_ff == lfps_pkg::MODE_SPIN_CW) || (mode_ff == lfps_pkg::MODE_SPIN_CCW);
      hold_in    = in_spin && mask_empty;

      // line back during a spin clears the remembered edge
      side_base = in_spin ? lfps_pkg::SIDE_NONE : last_side_ff;
      if (left_bit != right_bit) begin
         side_in = left_bit ? lfps_pkg::SIDE_LEFT : lfps_pkg::SIDE_RIGHT;
      end else begin
         side_in = side_base;
      end

      // substitute the lost-line error
      err_new = err_wide[ERR_W-1:0];
      if (mask_empty && side_in == lfps_pkg::SIDE_RIGHT) begin
         err_new = lfps_pkg::LOST_ERROR;
      end else if (mask_empty && side_in == lfps_pkg::SIDE_LEFT) begin
         err_new = -lfps_pkg::LOST_ERROR;
      end

      // integral: clear at zero error, else accumulate and clamp
      integ_sum = DIFF_W'(integ_ff) + DIFF_W'(err_new);
      if (err_new == '0) begin
         integ_in = '0;
      end else if (integ_sum > lfps_pkg::INTEG_MAX) begin
         integ_in = lfps_pkg::INTEG_MAX[INTEG_W-1:0];
      end else if (integ_sum < lfps_pkg::INTEG_MIN) begin
         integ_in = lfps_pkg::INTEG_MIN[INTEG_W-1:0];
      end else begin
         integ_in = integ_sum[INTEG_W-1:0];
      end
      diff_in = DIFF_W'(err_new) - DIFF_W'(prev_err_ff);

      // enter a spin on a substituted error with no sensor on the line
      spin_enter = mask_empty
                   && (err_new == lfps_pkg::LOST_ERROR || err_new == -lfps_pkg::LOST_ERROR);
      if (spin_enter) begin
         mode_new = (err_new == lfps_pkg::LOST_ERROR) ? lfps_pkg::MODE_SPIN_CW
                                                      : lfps_pkg::MODE_SPIN_CCW;
      end else begin
         mode_new = lfps_pkg::MODE_FOLLOW;
      end

      // a held spin repeats the previous error and keeps its mode
      err_b_in  = hold_in ? prev_err_ff : err_new;
      mode_b_in = hold_in ? mode_ff : mode_new;

      // spin speed numerators: (base - trim) * 9, zero when not positive
      spin_xl = $signed({2'b00, base_speed_ff}) - lfps_pkg::SPIN_X_W'(left_trim_ff);
      spin_xr = $signed({2'b00, base_speed_ff}) - lfps_pkg::SPIN_X_W'(right_trim_ff);
      if (spin_xl > 0) begin
         spin_yl_in = {1'b0, spin_xl[8:0], 3'b000} + {4'b0000, spin_xl[8:0]};
      end else begin
         spin_yl_in = '0;
      end
      if (spin_xr > 0) begin
         spin_yr_in = {1'b0, spin_xr[8:0], 3'b000} + {4'b0000, spin_xr[8:0]};
      end else begin
         spin_yr_in = '0;
      end
   end

   // update controller state as the item leaves the input stage, unless a spin is held
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= lfps_pkg::MODE_FOLLOW;
         last_side_ff <= lfps_pkg::SIDE_NONE;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
      end else if (adv_in && !hold_in) begin
         mode_ff      <= mode_new;
         last_side_ff <= side_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= err_new;
      end
   end

   // ------------------------------------------------------ error stage regs
   logic signed [ERR_W-1:0]       err_b_ff;
   logic signed [INTEG_W-1:0]     integ_b_ff;
   logic signed [DIFF_W-1:0]      diff_b_ff;
   logic                          hold_b_ff;
   logic [1:0]                    mode_b_ff;
   logic [lfps_pkg::SPIN_Y_W-1:0] spin_yl_b_ff, spin_yr_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_b_ff <= 1'b0;
      end else if (take_b) begin
         v_b_ff <= v_in_ff;
      end
      if (take_b) begin
         err_b_ff     <= err_b_in;
         integ_b_ff   <= integ_in;
         diff_b_ff    <= diff_in;
         hold_b_ff    <= hold_in;
         mode_b_ff    <= mode_b_in;
         spin_yl_b_ff <= spin_yl_in;
         spin_yr_b_ff <= spin_yr_in;
      end
   end

   // -------------------------------------------------------- multiplier stage
   logic signed [PP_W-1:0] prod_p;
   logic signed [PI_W-1:0] prod_i;
   logic signed [PD_W-1:0] prod_d;

   assign prod_p = $signed({1'b0, gain_p_ff}) * err_b_ff;
   assign prod_i = $signed({1'b0, gain_i_ff}) * integ_b_ff;
   assign prod_d = $signed({1'b0, gain_d_ff}) * diff_b_ff;

   logic signed [SUM_W-1:0]        prod_p_c_ff, prod_i_c_ff, prod_d_c_ff;
   logic [lfps_pkg::SPIN_Q_W-1:0]  spin_ql_c_ff, spin_qr_c_ff;
   logic signed [ERR_W-1:0]        err_c_ff;
   logic                           hold_c_ff;
   logic [1:0]                     mode_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_c_ff <= 1'b0;
      end else if (take_c) begin
         v_c_ff <= v_b_ff;
      end
      if (take_c) begin
         prod_p_c_ff  <= SUM_W'(prod_p);
         prod_i_c_ff  <= SUM_W'(prod_i);
         prod_d_c_ff  <= SUM_W'(prod_d);
         spin_ql_c_ff <= spin_yl_b_ff * lfps_pkg::RECIP_TEN;
         spin_qr_c_ff <= spin_yr_b_ff * lfps_pkg::RECIP_TEN;
         err_c_ff     <= err_b_ff;
         hold_c_ff    <= hold_b_ff;
         mode_c_ff    <= mode_b_ff;
      end
   end

   // ------------------------------------------------- sum, clamp and mix stage
   logic signed [SUM_W-1:0]           pid_sum;
   logic [SUM_W-1:0]                  pid_abs;
   logic [MAG_W-1:0]                  pid_mag;
   logic [lfps_pkg::SPEED_W-1:0]      mag_lim;
   logic signed [lfps_pkg::CORR_W-1:0] corr_in;
   logic signed [lfps_pkg::MIX_W-1:0] mix_l, mix_r;
   logic [lfps_pkg::SPIN_Q_W-lfps_pkg::RECIP_SH-1:0] spin_sl, spin_sr;
   logic [lfps_pkg::SPEED_W-1:0]      left_speed_in, right_speed_in;
   logic                              spin_out, left_fwd_in, right_fwd_in;

   always_comb begin
      // truncate toward zero, then clamp the magnitude
      pid_sum = prod_p_c_ff + prod_i_c_ff + prod_d_c_ff;
      pid_abs = pid_sum[SUM_W-1] ? $unsigned(-pid_sum) : $unsigned(pid_sum);
      pid_mag = pid_abs[SUM_W-1:GAIN_FRACTION_BITS];
      if (pid_mag > MAG_W'(max_corr_ff)) begin
         mag_lim = max_corr_ff;
      end else begin
         mag_lim = pid_mag[lfps_pkg::SPEED_W-1:0];
      end
      if (hold_c_ff) begin
         corr_in = '0;
      end else if (pid_sum[SUM_W-1]) begin
         corr_in = -$signed({1'b0, mag_lim});
      end else begin
         corr_in = $signed({1'b0, mag_lim});
      end

      // follow speeds
      mix_l = $signed({3'b000, base_speed_ff}) + lfps_pkg::MIX_W'(corr_in)
              - lfps_pkg::MIX_W'(left_trim_ff);
      mix_r = $signed({3'b000, base_speed_ff}) - lfps_pkg::MIX_W'(corr_in)
              - lfps_pkg::MIX_W'(right_trim_ff);

      // spin speeds: drop the reciprocal scaling
      spin_sl = spin_ql_c_ff[lfps_pkg::SPIN_Q_W-1:lfps_pkg::RECIP_SH];
      spin_sr = spin_qr_c_ff[lfps_pkg::SPIN_Q_W-1:lfps_pkg::RECIP_SH];

      spin_out = (mode_c_ff == lfps_pkg::MODE_SPIN_CW)
                 || (mode_c_ff == lfps_pkg::MODE_SPIN_CCW);
      if (spin_out) begin
         left_speed_in  = (spin_sl > 10'(lfps_pkg::SPEED_MAX)) ? lfps_pkg::SPEED_MAX
                                                              : spin_sl[7:0];
         right_speed_in = (spin_sr > 10'(lfps_pkg::SPEED_MAX)) ? lfps_pkg::SPEED_MAX
                                                              : spin_sr[7:0];
         left_fwd_in    = (mode_c_ff == lfps_pkg::MODE_SPIN_CW);
         right_fwd_in   = !left_fwd_in;
      end else begin
         if (mix_l < 0) begin
            left_speed_in = '0;
         end else if (mix_l > $signed({3'b000, lfps_pkg::SPEED_MAX})) begin
            left_speed_in = lfps_pkg::SPEED_MAX;
         end else begin
            left_speed_in = mix_l[7:0];
         end
         if (mix_r < 0) begin
            right_speed_in = '0;
         end else if (mix_r > $signed({3'b000, lfps_pkg::SPEED_MAX})) begin
            right_speed_in = lfps_pkg::SPEED_MAX;
         end else begin
            right_speed_in = mix_r[7:0];
         end
         left_fwd_in  = 1'b1;
         right_fwd_in = 1'b1;
      end
   end

   // ------------------------------------------------------------ result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_o_ff <= 1'b0;
      end else if (take_o) begin
         v_o_ff <= v_c_ff;
      end
      if (take_o) begin
         rsp_left_speed    <= left_speed_in;
         rsp_right_speed   <= right_speed_in;
         rsp_left_forward  <= left_fwd_in;
         rsp_right_forward <= right_fwd_in;
         rsp_line_error    <= err_c_ff;
         rsp_correction    <= corr_in;
         rsp_steer_mode    <= mode_c_ff;
      end
   end

   assign rsp_valid  = v_o_ff;
   assign rsp_update = 1'b1;

   // ------------------------------------------------------------ assertions
   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= 9'sd200) && (integ_ff >= -9'sd200))
      else $error("integral left its clamp range");

   a_hold_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (adv_in && hold_in) |=> (integ_ff == $past(integ_ff))
                              && (prev_err_ff == $past(prev_err_ff))
                              && (mode_ff == $past(mode_ff)))
      else $error("held spin tick changed PID state");

   a_corr_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_correction[8] && rsp_correction[7:0] <= max_corr_ff)
                     || (rsp_correction[8]
                         && ($unsigned(-rsp_correction) <= {1'b0, max_corr_ff}))))
      else $error("correction exceeds its clamp");

   a_follow_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_steer_mode == lfps_pkg::MODE_FOLLOW)
         |-> (rsp_left_forward && rsp_right_forward))
      else $error("follow command drives a wheel backward");

   a_spin_opposed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_steer_mode != lfps_pkg::MODE_FOLLOW)
         |-> (rsp_left_forward != rsp_right_forward))
      else $error("spin command without opposed wheels");

endmodule
